// ----- src/mef_pkg.sv -----
// ----------------------------------------------------------------------------
// mef_pkg
// Shared sizes, types and state codes of the majority element finder.
// ----------------------------------------------------------------------------
package mef_pkg;

   localparam int unsigned MAX_ITEMS = 1024;
   localparam int unsigned ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int unsigned VALUE_W   = 32;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0]   count_type;
   typedef logic [ADDR_W-1:0]  addr_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_FLUSH,
      ST_REPORT
   } state_type;

endpackage

// ----- src/majority_element_finder_unit.sv -----
// ----------------------------------------------------------------------------
// majority_element_finder_unit
// Strict-majority search over a set of signed 32-bit values.
// ----------------------------------------------------------------------------
// Flow: after the last transfer, ST_SCAN reads each stored item once,
//    ST_FLUSH waits out the read latency and ST_REPORT hands the answer over.
// Throughput: one item per cycle while loading; none is taken while a set is
//    scanned or reported; the scan is bound by the store's single read port.
// Reset: synchronous, active high; clears counters, vote and output valid.
//    The value store is not cleared: only entries of the current set are read.
// ----------------------------------------------------------------------------
module majority_element_finder_unit
   import mef_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] item_value
   input  logic        req_tlast,   // last_item
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] majority_value
   output logic        rsp_tuser    // [0] found
);

   // Control state
   state_type state_ff, state_in;
   count_type count_ff, count_in;       // items stored in this set
   value_type cand_ff, cand_in;         // vote candidate
   count_type vote_ff, vote_in;         // votes for the candidate
   count_type hits_ff, hits_in;         // candidate matches found by the scan
   addr_type  scan_ff, scan_in;         // scan read address
   logic      rd_valid_ff, rd_valid_in; // read data valid this cycle
   logic      rsp_valid_ff, rsp_valid_in;

   // Output payload register
   value_type rsp_value_ff;
   logic      rsp_found_ff;

   // Control decode
   logic      accept;
   logic      store_ok;
   logic      scan_issue;
   logic      scan_last;
   logic      report_fire;
   logic      found_now;

   // Value store ports
   logic      ram_we;
   value_type ram_rdata;

   assign accept    = req_tvalid & req_tready;
   // Drop items once the store is full; they neither store nor vote.
   assign store_ok  = (count_ff != CNT_W'(MAX_ITEMS));
   assign ram_we    = accept & store_ok;
   assign scan_last = (CNT_W'(scan_ff) == (count_ff - CNT_W'(1)));
   assign found_now = (count_ff != '0) && (hits_ff > (count_ff >> 1));

   mef_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(MAX_ITEMS)
   ) u_value_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(count_ff[ADDR_W-1:0]),
      .wr_data(req_tdata),
      .rd_addr(scan_ff),
      .rd_data(ram_rdata)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_tlast) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // wait out the read latency of the final scan read
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (report_fire) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // State outputs
   always_comb begin
      req_tready  = 1'b0;
      scan_issue  = 1'b0;
      report_fire = 1'b0;
      case (state_ff)
         ST_LOAD:   req_tready  = 1'b1;
         ST_SCAN:   scan_issue  = 1'b1;
         ST_FLUSH:  report_fire = 1'b0;
         // Hand the answer over only when the output register is free.
         ST_REPORT: report_fire = ~rsp_valid_ff | rsp_tready;
         default:   req_tready  = 1'b0;
      endcase
   end

   // Datapath: vote while loading, count while scanning
   always_comb begin
      count_in = count_ff;
      cand_in  = cand_ff;
      vote_in  = vote_ff;
      hits_in  = hits_ff;
      scan_in  = scan_ff;

      if (ram_we) begin
         count_in = count_ff + CNT_W'(1);
         if (vote_ff == '0) begin
            cand_in = req_tdata;
            vote_in = CNT_W'(1);
         end else if (req_tdata == cand_ff) begin
            vote_in = vote_ff + CNT_W'(1);
         end else begin
            vote_in = vote_ff - CNT_W'(1);
         end
      end

      if (scan_issue) begin
         scan_in = scan_last ? '0 : scan_ff + ADDR_W'(1);
      end

      if (rd_valid_ff && (ram_rdata == cand_ff)) begin
         hits_in = hits_ff + CNT_W'(1);
      end

      // Clear the set once the answer has moved to the output register.
      if (report_fire) begin
         count_in = '0;
         cand_in  = '0;
         vote_in  = '0;
         hits_in  = '0;
         scan_in  = '0;
      end
   end

   assign rd_valid_in  = scan_issue;
   assign rsp_valid_in = report_fire | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         cand_ff      <= '0;
         vote_ff      <= '0;
         hits_ff      <= '0;
         scan_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cand_ff      <= cand_in;
         vote_ff      <= vote_in;
         hits_ff      <= hits_in;
         scan_ff      <= scan_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the answer; hold it while the consumer stalls.
   always_ff @(posedge clock) begin
      if (report_fire) begin
         rsp_value_ff <= found_now ? cand_ff : '0;
         rsp_found_ff <= found_now;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_found_ff;

`ifndef SYNTH
   // The set never grows past the store.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("item count exceeds store depth");

   // Votes and hits can never outnumber the stored items.
   a_vote_bound: assert property (@(posedge clock) disable iff (reset)
      (vote_ff <= count_ff) && (hits_ff <= count_ff))
      else $error("vote or hit count exceeds item count");

   // The store is written only while loading, never during a scan.
   a_write_in_load: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_LOAD))
      else $error("value store written outside load");

   // Read data arrives only right after a scan read.
   a_read_follows_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> ($past(state_ff) == ST_SCAN))
      else $error("read data valid without a scan read");

   // A report with a free output register always presents a result.
   a_report_presents: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("report did not load the output register");
`endif

endmodule

// ----- src/mef_ram.sv -----
// ----------------------------------------------------------------------------
// mef_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mef_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/majority_tally_checker.sv -----
// ----------------------------------------------------------------------------
// majority_tally_checker
// Watches both streams of the majority element finder, keeps its own vote
// and element store, and compares every result with the predicted one.
// ----------------------------------------------------------------------------
module majority_tally_checker
   import mef_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] item_value
   input  logic        req_tlast,   // last_item
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] majority_value
   input  logic        rsp_tuser,   // [0] found
   output int          pending_results,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      value_type value;
      logic      found;
   } verdict_type;

   value_type   element_store [MAX_ITEMS];
   count_type   stored_count;
   value_type   candidate_value;
   count_type   vote_count;
   verdict_type verdict_queue [$];

   // Count the surviving candidate over the stored set; a strict majority wins.
   function automatic verdict_type count_candidate();
      count_type   hits;
      verdict_type verdict;
      hits = '0;
      for (int i = 0; i < int'(stored_count); i++) begin
         if (element_store[ADDR_W'(i)] == candidate_value) hits++;
      end
      if (stored_count != '0 && hits > stored_count / 2) begin
         verdict.value = candidate_value;
         verdict.found = 1'b1;
      end else begin
         verdict.value = '0;
         verdict.found = 1'b0;
      end
      return verdict;
   endfunction

   always @(posedge clock) begin
      verdict_type wanted;
      if (reset) begin
         stored_count    = '0;
         candidate_value = '0;
         vote_count      = '0;
         verdict_queue.delete();
         pending_results = 0;
         fail_count      = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_queue.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result majority_value %h found %b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               wanted = verdict_queue.pop_front();
               if (rsp_tdata !== wanted.value) begin
                  fail_count++;
                  $display("%0t: majority_value expected %h, got %h",
                           $time, wanted.value, rsp_tdata);
               end
               if (rsp_tuser !== wanted.found) begin
                  fail_count++;
                  $display("%0t: found expected %b, got %b",
                           $time, wanted.found, rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            // a full store drops the item: no write and no vote
            if (int'(stored_count) < MAX_ITEMS) begin
               element_store[stored_count[ADDR_W-1:0]] = req_tdata;
               stored_count++;
               if (vote_count == '0) begin
                  candidate_value = req_tdata;
                  vote_count      = CNT_W'(1);
               end else if (req_tdata == candidate_value) begin
                  vote_count++;
               end else begin
                  vote_count--;
               end
            end
            if (req_tlast) begin
               verdict_queue.push_back(count_candidate());
               stored_count    = '0;
               candidate_value = '0;
               vote_count      = '0;
            end
         end
         pending_results = verdict_queue.size();
      end
   end

endmodule

// ----- tb/tb_majority_element_finder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_majority_element_finder_unit
// Feeds sets of signed values to the majority element finder with random
// gaps and back-pressure; a checker beside the block predicts each result.
// ----------------------------------------------------------------------------
module tb_majority_element_finder_unit;
   import mef_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1600;
   localparam int HOLD_CYCLES  = 1500;
   localparam int TAIL_CYCLES  = MAX_ITEMS + 64;

   // how the values of one set are chosen
   typedef enum int {
      SET_PLANTED,   // one value holds a strict majority
      SET_HALF,      // one value holds exactly half, rounded down
      SET_POOL,      // values drawn from a pool of three
      SET_NOISE      // fully random values
   } set_kind_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [31:0] item_value
   logic        req_tlast;    // last_item
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [31:0] majority_value
   logic        rsp_tuser;    // [0] found

   int          pending_results;
   int          fail_count;

   value_type   set_values [$];
   value_type   lead_value;
   bit          hold_request;

   majority_element_finder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   majority_tally_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .pending_results (pending_results),
      .fail_count      (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly no gap, often a short one, rarely a long one.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Lean on the extremes and on small values near zero.
   function automatic value_type pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
         3, 4, 5: return value_type'($urandom_range(0, 6) - 3);
         default: return $urandom;
      endcase
   endfunction

   // Fill set_values with one shuffled set of the given shape.
   task automatic build_set(input int size, input set_kind_type kind);
      value_type pool [3];
      value_type swap;
      int        lead_hits;
      int        j;
      set_values.delete();
      lead_value = pick_value();
      foreach (pool[k]) pool[k] = pick_value();
      case (kind)
         SET_PLANTED: lead_hits = $urandom_range(size / 2 + 1, size);
         SET_HALF:    lead_hits = size / 2;
         default:     lead_hits = 0;
      endcase
      for (int i = 0; i < size; i++) begin
         if (i < lead_hits)        set_values.push_back(lead_value);
         else if (kind == SET_NOISE) set_values.push_back($urandom);
         else                      set_values.push_back(pool[2'($urandom_range(0, 2))]);
      end
      for (int i = size - 1; i > 0; i--) begin
         j             = $urandom_range(0, i);
         swap          = set_values[i];
         set_values[i] = set_values[j];
         set_values[j] = swap;
      end
   endtask

   // Offer one item and hold it until the transfer; valid stays high when
   // no gap follows, so the next item goes out back to back.
   task automatic send_item(input value_type value, input logic last, input bit no_gaps);
      int gap;
      req_tdata  <= value;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      gap = no_gaps ? 0 : idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drive set_values as one set; flag the final element.
   task automatic send_set(input bit no_gaps);
      foreach (set_values[i]) send_item(set_values[i], i == set_values.size() - 1, no_gaps);
   endtask

   // Drop valid and hold until every predicted result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      wait (pending_results == 0);
      @(negedge clock);
   endtask

   // Result side: bursts of ready, random stalls, and one long hold-off
   // counted here once the stimulus asks for it.
   initial begin
      int  run;
      bit  hold_done;
      rsp_tready = 1'b0;
      hold_done  = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            run = ($urandom_range(0, 9) < 2) ? $urandom_range(20, 80) : $urandom_range(1, 4);
            rsp_tready <= 1'b1;
            repeat (run) @(negedge clock);
            run = idle_length();
            if (run > 0) begin
               rsp_tready <= 1'b0;
               repeat (run) @(negedge clock);
            end
         end
      end
   end

   // Stop a hung run.
   initial begin
      #8_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int           items_sent;
      int           set_index;
      int           size;
      int           roll;
      bit           overflow_done;
      set_kind_type kind;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      hold_request = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed sets: single extremes, zero as a found value, even and odd
      // splits, exact half, a set whose last element decides, no majority.
      set_values = '{32'h8000_0000};                        send_set(1'b0);
      set_values = '{32'h7FFF_FFFF};                        send_set(1'b0);
      set_values = '{32'h0};                                send_set(1'b0);
      set_values = '{32'hFFFF_FFFF, 32'h0};                 send_set(1'b0);
      set_values = '{32'd5, 32'd5};                         send_set(1'b1);
      set_values = '{32'd1, 32'd2, 32'd2};                  send_set(1'b0);
      set_values = '{32'd3, 32'd4, 32'd3, 32'd4};           send_set(1'b0);
      set_values = '{32'd7, 32'd8, 32'd9};                  send_set(1'b1);
      set_values = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0000, 32'h7FFF_FFFF};         send_set(1'b0);
      drain_results();

      // Random sets; the receiver holds off early on while items keep coming.
      hold_request  = 1'b1;
      items_sent    = 0;
      set_index     = 0;
      overflow_done = 1'b0;
      while (items_sent < RANDOM_ITEMS) begin
         if (!overflow_done && items_sent >= 300) begin
            // Fill the store with exactly half of one value, then offer more
            // of it: the extra items must be dropped, so no majority.
            overflow_done = 1'b1;
            build_set(MAX_ITEMS, SET_HALF);
            repeat ($urandom_range(1, 3)) set_values.push_back(lead_value);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70)      size = $urandom_range(1, 12);
            else if (roll < 95) size = $urandom_range(13, 64);
            else                size = $urandom_range(65, 300);
            roll = $urandom_range(0, 99);
            if (roll < 50)      kind = SET_PLANTED;
            else if (roll < 65) kind = SET_HALF;
            else if (roll < 85) kind = SET_POOL;
            else                kind = SET_NOISE;
            build_set(size, kind);
         end
         send_set($urandom_range(0, 4) == 0);
         items_sent += set_values.size();
         set_index++;
         if (set_index % 20 == 0) drain_results();
      end

      // Let everything in flight land, then allow a full scan of quiet time.
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
